FILE: src/assert_macros.svh
// Assertion macros for the allocator RTL, included by the allocator top.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AR(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);
`else
`define ASSERT_AR(lbl, ck, rn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rn, expr, msg)
`endif
`endif

FILE: src/rbsa_pkg.sv
// Types and constants of the slot allocator.
// No dependencies; imported by rbsa_find, the allocator top and the testbench.
`default_nettype none
package rbsa_pkg;
	localparam int WORD_W   = 32;
	localparam int WORD_LOG = 5;
	localparam int SC_W     = 13;
	localparam int SC_MAX   = 8191;
	localparam int SLOT_W   = 12;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_MARK    = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [SLOT_W-1:0] slot;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic [1:0]        status;
		logic [SLOT_W-1:0] free_slots;
	} out_item_t;

	typedef struct packed {
		logic first;
		logic last;
	} scan_ctl_t;

	typedef struct packed {
		logic                hit;
		logic [WORD_LOG-1:0] pos;
	} find_res_t;
endpackage
`default_nettype wire

FILE: src/rbsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rbsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: src/rbsa_find.sv
// Masks one bitmap row to the live scan window and finds its lowest free slot.
// Depends on rbsa_pkg.
`default_nettype none
module rbsa_find import rbsa_pkg::*; #(
	parameter int ROW_AW = 7,
	parameter int CMP_W  = 13
) (
	input  wire logic [2*WORD_W-1:0] row_data,
	input  wire logic [ROW_AW-1:0]   row,
	input  wire logic [SC_W-1:0]     slot_count,
	input  wire logic [SC_W-1:0]     start,
	input  wire scan_ctl_t           ctl,
	output find_res_t                res
);
	logic [WORD_W-1:0] used_w;
	logic [WORD_W-1:0] rsv_w;
	logic [WORD_W-1:0] cand;
	logic [CMP_W-1:0]  sc_x;
	logic [CMP_W-1:0]  k_x;

	assign used_w = row_data[2*WORD_W-1:WORD_W];
	assign rsv_w  = row_data[WORD_W-1:0];
	assign sc_x   = CMP_W'(slot_count);
	assign k_x    = CMP_W'(start);

	always_comb begin
		logic [CMP_W-1:0] s;
		s = '0;
		for (int b = 0; b < WORD_W; b++) begin
			s = CMP_W'({row, WORD_LOG'(b)});
			cand[b] = !used_w[b] && !rsv_w[b] && (s != '0) && (s < sc_x)
				&& (!ctl.first || s >= k_x) && (!ctl.last || s < k_x);
		end
	end

	always_comb begin
		res.hit = |cand;
		res.pos = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				res.pos = WORD_LOG'(b);
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/reserving_bitmap_slot_allocator_top.sv
// Next-fit bitmap slot allocator; bitmaps in rbsa_ram rows of 32 slots, scan in rbsa_find.
// Release, mark, clear: row read, write-back in ST_RMW, then the result; an ignored slot skips both.
// Allocate: one row read per cycle from the cursor row until a free slot is found or the
// scan wraps back to the cursor row; at a zero free count no row is read and it reports full.
// A new input transfer is taken once the previous result sits in the output register.
// Reset and each slot_count write: clear pass over all ceil(MAX_SLOTS/32) rows, in_ready low.
`default_nettype none
module reserving_bitmap_slot_allocator_top import rbsa_pkg::*; #(
	parameter int MAX_SLOTS = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [SC_W-1:0] cfg_data,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire in_item_t        in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output out_item_t            out_data
);
`include "assert_macros.svh"

	localparam int NUM_ROWS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int CMP_W    = (ROW_AW + WORD_LOG > SC_W) ? ROW_AW + WORD_LOG : SC_W;
	localparam int SC_RST   = (MAX_SLOTS > SC_MAX) ? SC_MAX : MAX_SLOTS;

	state_t state_q, state_d;
	logic [SC_W-1:0]   sc_q, cursor_q, free_q, k_q, slot_q;
	logic [1:0]        action_q;
	logic [ROW_AW-1:0] clr_row_q, iss_row_q, chk_row_q;
	logic [ROW_AW:0]   iss_v_q, chk_v_q;
	logic [SLOT_W-1:0] res_granted_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic                ram_we, ram_re;
	logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
	logic [2*WORD_W-1:0] ram_wdata, ram_rdata;

	logic              in_xfer, out_load;
	logic [SC_W-1:0]   in_slot, k_norm, cfg_clamp, sc_m1, hit_slot;
	logic              bad_slot;
	logic [ROW_AW-1:0] last_row, start_row, start_next, iss_next, in_row, slot_row;
	logic [ROW_AW:0]   last_v;
	logic [WORD_LOG-1:0] slot_bit;
	scan_ctl_t         sctl;
	find_res_t         fres;
	logic              scan_hit, scan_end;
	logic [2*WORD_W-1:0] rmw_wdata, alloc_wdata;
	logic [SC_W-1:0]   rmw_free;

	assign in_ready  = (state_q == ST_IDLE) && !cfg_we;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign sc_m1      = sc_q - SC_W'(1);
	assign in_slot    = SC_W'(in_data.slot);
	assign bad_slot   = (in_slot == '0) || (in_slot >= sc_q);
	assign k_norm     = ((cursor_q == '0) || (cursor_q >= sc_q)) ? SC_W'(1) : cursor_q;
	assign last_row   = ROW_AW'(sc_m1 >> WORD_LOG);
	assign last_v     = {1'b0, last_row} + (ROW_AW+1)'(1);
	assign start_row  = ROW_AW'(k_norm >> WORD_LOG);
	assign start_next = (start_row == last_row) ? '0 : start_row + ROW_AW'(1);
	assign iss_next   = (iss_row_q == last_row) ? '0 : iss_row_q + ROW_AW'(1);
	assign in_row     = ROW_AW'(in_slot >> WORD_LOG);
	assign slot_row   = ROW_AW'(slot_q >> WORD_LOG);
	assign slot_bit   = slot_q[WORD_LOG-1:0];

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamp = SC_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
			cfg_clamp = SC_W'(SC_RST);
		end else begin
			cfg_clamp = cfg_data;
		end
	end

	rbsa_ram #(
		.WIDTH(2 * WORD_W),
		.DEPTH(NUM_ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sctl = {(chk_v_q == '0), (chk_v_q == last_v)};

	rbsa_find #(
		.ROW_AW(ROW_AW),
		.CMP_W (CMP_W)
	) u_find (
		.row_data  (ram_rdata),
		.row       (chk_row_q),
		.slot_count(sc_q),
		.start     (k_q),
		.ctl       (sctl),
		.res       (fres)
	);

	assign scan_hit    = (state_q == ST_SCAN) && fres.hit;
	assign scan_end    = (state_q == ST_SCAN) && !fres.hit && (chk_v_q == last_v);
	assign hit_slot    = SC_W'({chk_row_q, fres.pos});
	assign alloc_wdata = ram_rdata | ((2*WORD_W)'(1) << fres.pos);

	// read-modify-write of one slot for release, mark and clear
	always_comb begin
		logic [WORD_W-1:0] used_n, rsv_n;
		logic              ub, rb, up_ok;
		logic [SC_W-1:0]   f1;
		used_n   = ram_rdata[2*WORD_W-1:WORD_W];
		rsv_n    = ram_rdata[WORD_W-1:0];
		ub       = used_n[slot_bit];
		rb       = rsv_n[slot_bit];
		up_ok    = free_q < sc_m1;
		f1       = free_q;
		rmw_free = free_q;
		case (action_q)
			ACT_RELEASE: begin
				rsv_n[slot_bit] = 1'b0;
				rmw_free = (rb && up_ok) ? free_q + SC_W'(1) : free_q;
			end
			ACT_MARK: begin
				rsv_n[slot_bit]  = 1'b0;
				used_n[slot_bit] = 1'b1;
				f1 = (rb && up_ok) ? free_q + SC_W'(1) : free_q;
				rmw_free = (!ub && f1 != '0) ? f1 - SC_W'(1) : f1;
			end
			ACT_CLEAR: begin
				used_n[slot_bit] = 1'b0;
				rmw_free = (ub && up_ok) ? free_q + SC_W'(1) : free_q;
			end
			default: begin
				rmw_free = free_q;
			end
		endcase
		rmw_wdata = {used_n, rsv_n};
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_row;
		ram_wdata = rmw_wdata;
		ram_re    = 1'b0;
		ram_raddr = iss_row_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_row_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_data.action == ACT_ALLOC) begin
						ram_re    = (free_q != '0);
						ram_raddr = start_row;
					end else begin
						ram_re    = !bad_slot;
						ram_raddr = in_row;
					end
				end
			end
			ST_RMW: begin
				ram_we = 1'b1;
			end
			ST_SCAN: begin
				if (fres.hit) begin
					ram_we    = 1'b1;
					ram_waddr = chk_row_q;
					ram_wdata = alloc_wdata;
				end else begin
					ram_re = (iss_v_q <= last_v);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_row_q == ROW_AW'(NUM_ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_data.action == ACT_ALLOC) begin
						state_d = (free_q == '0) ? ST_DONE : ST_SCAN;
					end else begin
						state_d = bad_slot ? ST_DONE : ST_RMW;
					end
				end
			end
			ST_RMW: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (scan_hit || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_d = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sc_q        <= SC_W'(SC_RST);
			cursor_q    <= SC_W'(1);
			free_q      <= SC_W'(SC_RST - 1);
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sc_q      <= cfg_clamp;
				cursor_q  <= SC_W'(1);
				free_q    <= cfg_clamp - SC_W'(1);
				clr_row_q <= '0;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_row_q <= clr_row_q + ROW_AW'(1);
					end
					ST_RMW: begin
						free_q <= rmw_free;
						if (action_q == ACT_CLEAR) begin
							cursor_q <= slot_q;
						end
					end
					ST_SCAN: begin
						if (fres.hit) begin
							cursor_q <= hit_slot + SC_W'(1);
							if (free_q != '0) begin
								free_q <= free_q - SC_W'(1);
							end
						end
					end
					default: begin
						clr_row_q <= clr_row_q;
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_q      <= in_data.action;
			slot_q        <= in_slot;
			k_q           <= k_norm;
			chk_row_q     <= start_row;
			chk_v_q       <= '0;
			iss_row_q     <= start_next;
			iss_v_q       <= (ROW_AW+1)'(1);
			res_granted_q <= '0;
			if (in_data.action == ACT_ALLOC) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= bad_slot ? STAT_BAD : STAT_OK;
			end
		end else if (state_q == ST_SCAN) begin
			if (fres.hit) begin
				res_granted_q <= hit_slot[SLOT_W-1:0];
				res_status_q  <= STAT_OK;
			end else begin
				chk_row_q <= iss_row_q;
				chk_v_q   <= iss_v_q;
				if (ram_re) begin
					iss_row_q <= iss_next;
					iss_v_q   <= iss_v_q + (ROW_AW+1)'(1);
				end
			end
		end
		if (out_load) begin
			out_q.granted_slot <= res_granted_q;
			out_q.status       <= res_status_q;
			out_q.free_slots   <= free_q[SLOT_W-1:0];
		end
	end

	`ASSERT_AR(a_free_in_range, clk, arst_n, free_q < sc_q, "free count above slot_count - 1")
	`ASSERT_AR(a_grant_in_range, clk, arst_n, scan_hit |-> (hit_slot != '0 && hit_slot < sc_q), "grant outside slots 1 .. slot_count-1")
	`ASSERT_AR(a_full_when_empty, clk, arst_n, (in_xfer && in_data.action == ACT_ALLOC && free_q == '0) |=> (state_q == ST_DONE && res_status_q == STAT_FULL), "allocate at zero free count not reported full")
	`ASSERT_AR(a_scan_keeps_reading, clk, arst_n, (state_q == ST_SCAN && !scan_hit && !scan_end) |-> ram_re, "scan stalled without a row read")
	`ASSERT_NEVER(a_no_write_in_idle, clk, arst_n, (state_q == ST_IDLE || state_q == ST_DONE) && ram_we, "bitmap write outside clear or update")
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for reserving_bitmap_slot_allocator_top.
// Holds a slot-allocator mirror class that predicts each response and checks it in order.
// Depends on rbsa_pkg and the allocator RTL only.
module tb import rbsa_pkg::*;;

	localparam int NSLOTS      = 4096;
	localparam int WDOG_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 160;

	typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

	class allocator_mirror_t;
		bit          used_bits [NSLOTS];
		bit          rsvd_bits [NSLOTS];
		int unsigned cursor;
		int unsigned free_cnt;
		int unsigned count;
		out_item_t   pending_results [$];
		logic [SLOT_W-1:0] held [$];
		int unsigned errors, n_checked, n_grants, n_full, n_ignored;

		function new();
			set_count(NSLOTS);
		endfunction

		function void set_count(int unsigned v);
			v = v & 13'h1fff;
			if (v < 1) v = 1;
			if (v > NSLOTS) v = NSLOTS;
			count = v;
			foreach (used_bits[i]) begin
				used_bits[i] = 1'b0;
				rsvd_bits[i] = 1'b0;
			end
			cursor = 1;
			free_cnt = count - 1;
			held.delete();
		endfunction

		function void give_back();
			if (free_cnt < count - 1) free_cnt++;
		endfunction

		function void take_one();
			if (free_cnt > 0) free_cnt--;
		endfunction

		function void note_request(in_item_t it);
			out_item_t   r;
			int unsigned k;
			int unsigned s;
			r = '0;
			s = 32'(it.slot);
			if (it.action == ACT_ALLOC) begin
				r.status = STAT_FULL;
				if (free_cnt != 0) begin
					k = cursor;
					for (int i = 0; i < count; i++) begin
						if (k == 0 || k >= count) k = 1;
						if (!used_bits[k] && !rsvd_bits[k]) begin
							rsvd_bits[k] = 1'b1;
							cursor = k + 1;
							take_one();
							r.granted_slot = SLOT_W'(k);
							r.status = STAT_OK;
							break;
						end
						k++;
					end
				end
				if (r.status == STAT_OK) begin
					n_grants++;
					held.push_back(r.granted_slot);
					if (held.size() > 32) void'(held.pop_front());
				end else begin
					n_full++;
				end
			end else if (s == 0 || s >= count) begin
				r.status = STAT_BAD;
				n_ignored++;
			end else begin
				case (it.action)
					ACT_RELEASE: begin
						if (rsvd_bits[s]) begin
							rsvd_bits[s] = 1'b0;
							give_back();
						end
					end
					ACT_MARK: begin
						if (rsvd_bits[s]) begin
							rsvd_bits[s] = 1'b0;
							give_back();
						end
						if (!used_bits[s]) begin
							used_bits[s] = 1'b1;
							take_one();
						end
					end
					default: begin
						if (used_bits[s]) begin
							used_bits[s] = 1'b0;
							give_back();
						end
						cursor = s;
					end
				endcase
			end
			r.free_slots = SLOT_W'(free_cnt);
			pending_results.push_back(r);
		endfunction

		function void check_response(out_item_t got);
			out_item_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected response: granted_slot %0d status %0d free_slots %0d",
					got.granted_slot, got.status, got.free_slots);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			n_checked++;
			if (got.granted_slot !== e.granted_slot) begin
				$error("granted_slot: expected %0d, actual %0d", e.granted_slot, got.granted_slot);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.free_slots !== e.free_slots) begin
				$error("free_slots: expected %0d, actual %0d", e.free_slots, got.free_slots);
				errors++;
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [SC_W-1:0] cfg_data;
	logic            in_valid;
	logic            in_ready;
	in_item_t        in_data;
	logic            out_valid;
	logic            out_ready;
	out_item_t       out_data;

	allocator_mirror_t sb = new();
	int unsigned     tx_idle_pct;
	int unsigned     rx_stall_pct;
	bit              hold_req;
	int unsigned     n_sent;
	int unsigned     n_settings;

	reserving_bitmap_slot_allocator_top #(.MAX_SLOTS(NSLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side: check every transfer, then pick next ready
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_response(out_data);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("tb: watchdog expired after %0d cycles without a transfer", WDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic in_item_t req(logic [1:0] act, int unsigned s);
		in_item_t it;
		it.action = act;
		it.slot = SLOT_W'(s);
		return it;
	endfunction

	function automatic in_item_t rand_item();
		in_item_t    it;
		int unsigned r;
		r = $urandom_range(99);
		it.action = (r < 40) ? ACT_ALLOC : (r < 60) ? ACT_RELEASE : (r < 80) ? ACT_MARK : ACT_CLEAR;
		r = $urandom_range(99);
		if (r < 10)
			it.slot = SLOT_W'($urandom_range(4095));
		else if (r < 14)
			it.slot = '0;
		else if (r < 55 && sb.held.size() > 0)
			it.slot = sb.held[$urandom_range(sb.held.size() - 1)];
		else if (sb.count > 1)
			it.slot = SLOT_W'($urandom_range(sb.count - 1, 1));
		else
			it.slot = SLOT_W'($urandom_range(4095));
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(it);
		n_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	task automatic write_count(input logic [SC_W-1:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(32'(v));
		n_settings++;
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_TX: begin
				tx_idle_pct = 54;
				rx_stall_pct = 0;
			end
			IDLE_RX: begin
				tx_idle_pct = 0;
				rx_stall_pct = 54;
			end
			IDLE_BOTH: begin
				tx_idle_pct = 13;
				rx_stall_pct = 13;
			end
			default: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
		endcase
	endtask

	task automatic run_phase(input logic [SC_W-1:0] cnt, input int unsigned n,
			input idle_mode_t mode, input bit squeeze);
		write_count(cnt);
		set_idle(mode);
		if (squeeze) hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == n / 2) drain_results();
			send_item(rand_item());
		end
	endtask

	task automatic directed_items();
		set_idle(IDLE_NONE);
		// reset size: top slot, slot zero, repeated release
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_ALLOC, 4095));
		send_item(req(ACT_MARK, 4095));
		send_item(req(ACT_CLEAR, 4095));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_RELEASE, 4095));
		send_item(req(ACT_RELEASE, 4095));
		send_item(req(ACT_MARK, 0));
		send_item(req(ACT_CLEAR, 0));
		send_item(req(ACT_RELEASE, 0));
		// four slots: full, mark twice, clear of unused slot, wrap
		write_count(SC_W'(4));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_MARK, 3));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_MARK, 1));
		send_item(req(ACT_MARK, 1));
		send_item(req(ACT_CLEAR, 2));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_RELEASE, 2));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_CLEAR, 4));
		send_item(req(ACT_RELEASE, 4095));
		send_item(req(ACT_CLEAR, 3));
		send_item(req(ACT_ALLOC, 0));
		send_item(req(ACT_ALLOC, 0));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		hold_req = 1'b0;
		n_sent = 0;
		n_settings = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		directed_items();
		run_phase(SC_W'(0),    20,  IDLE_NONE, 1'b0);
		run_phase(SC_W'(8191), 60,  IDLE_TX,   1'b0);
		run_phase(SC_W'(2),    60,  IDLE_RX,   1'b0);
		run_phase(SC_W'(17),   150, IDLE_BOTH, 1'b1);
		run_phase(SC_W'(33),   150, IDLE_NONE, 1'b0);
		run_phase(SC_W'(64),   150, IDLE_TX,   1'b0);
		run_phase(SC_W'(100),  150, IDLE_RX,   1'b0);
		run_phase(SC_W'(4096), 60,  IDLE_BOTH, 1'b0);
		run_phase(SC_W'(5),    150, IDLE_NONE, 1'b0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d requests checked (%0d grants, %0d full, %0d ignored)",
			sb.n_checked, sb.n_grants, sb.n_full, sb.n_ignored);
		$display("tb: %0d slot-count writes incl. 0 and 8191, with gaps, stalls and a long hold",
			n_settings);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
